@@ rtl/mr_pkg.sv @@
// shared types and constants for the miller-rabin prime tester
package mr_pkg;

  localparam int WordWidth = 64;
  localparam int BaseCount = 15;
  localparam int BaseIdxW = 4;

  // controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_BASE,
    ST_POW_STEP,
    ST_POW_MUL,
    ST_POW_SQR,
    ST_CHECK,
    ST_SQR,
    ST_SQR_CHK,
    ST_DONE
  } mr_state_t;

  // datapath register updates
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_SHIFT_D,
    OP_LOAD_BASE,
    OP_MUL_RB,
    OP_MUL_BB,
    OP_MUL_XX,
    OP_NEXT_BASE
  } mr_op_t;

  // multiplier operand pairs
  typedef enum logic [1:0] {
    SEL_RB,
    SEL_BB,
    SEL_XX
  } mr_sel_t;

  typedef struct packed {
    mr_op_t  op;
    mr_sel_t sel;
    logic    mul_start;
  } mr_cmd_t;

  typedef struct packed {
    logic trivial;
    logic trivial_prime;
    logic d_even;
    logic base_ok;
    logic e_zero;
    logic e_bit;
    logic mul_busy;
    logic x_one;
    logic x_nm1;
    logic r_done;
  } mr_status_t;

  // witness base table
  function automatic logic [5:0] base_at(input logic [BaseIdxW-1:0] idx);
    logic [5:0] b;
    unique case (idx)
      4'd0: b = 6'd2;
      4'd1: b = 6'd3;
      4'd2: b = 6'd5;
      4'd3: b = 6'd7;
      4'd4: b = 6'd11;
      4'd5: b = 6'd13;
      4'd6: b = 6'd17;
      4'd7: b = 6'd19;
      4'd8: b = 6'd23;
      4'd9: b = 6'd29;
      4'd10: b = 6'd31;
      4'd11: b = 6'd37;
      4'd12: b = 6'd41;
      4'd13: b = 6'd43;
      4'd14: b = 6'd47;
      default: b = 6'd0;
    endcase
    return b;
  endfunction

endpackage

@@ rtl/mr_mulmod.sv @@
// bit-serial modular multiplier, one shift-and-add step a cycle
module mr_mulmod #(
  parameter int W = mr_pkg::WordWidth
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  input  logic [W-1:0] m,
  output logic         busy,
  output logic [W-1:0] result
);
  import mr_pkg::*;

  logic [W-1:0] a_r, a_nxt, b_r, b_nxt, acc_r, acc_nxt;
  logic busy_r, busy_nxt;
  logic [W:0] sum_acc, sum_dbl;

  // operands are already reduced below m
  always_comb begin
    sum_acc = {1'b0, acc_r} + {1'b0, a_r};
    sum_dbl = {1'b0, a_r} + {1'b0, a_r};
    a_nxt = a_r;
    b_nxt = b_r;
    acc_nxt = acc_r;
    busy_nxt = busy_r;
    if (start) begin
      a_nxt = a;
      b_nxt = b;
      acc_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (b_r == '0) begin
        busy_nxt = 1'b0;
      end else begin
        if (b_r[0]) begin
          acc_nxt = (sum_acc >= {1'b0, m}) ? W'(sum_acc - {1'b0, m}) : W'(sum_acc);
        end
        a_nxt = (sum_dbl >= {1'b0, m}) ? W'(sum_dbl - {1'b0, m}) : W'(sum_dbl);
        b_nxt = b_r >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    a_r <= a_nxt;
    b_r <= b_nxt;
    acc_r <= acc_nxt;
  end

  assign busy = busy_r;
  assign result = acc_r;
endmodule

@@ rtl/mr_datapath.sv @@
// datapath: candidate, exponent, witness value and the shared multiplier
module mr_datapath #(
  parameter int W = mr_pkg::WordWidth
) (
  input  logic                clk,
  input  logic                rst_n,
  input  mr_pkg::mr_cmd_t     cmd,
  input  logic [W-1:0]        cand,
  output mr_pkg::mr_status_t  status
);
  import mr_pkg::*;

  localparam int SW = $clog2(W + 1);

  logic [W-1:0] n_r, n_nxt, d_r, d_nxt, e_r, e_nxt;
  logic [W-1:0] r_r, r_nxt, b_r, b_nxt;
  logic [SW-1:0] s_r, s_nxt, cnt_r, cnt_nxt;
  logic [BaseIdxW-1:0] idx_r, idx_nxt;
  logic [W-1:0] nm1, ma, mb, mres, base_v;
  logic mbusy;

  assign nm1 = n_r - W'(1);
  assign base_v = W'(base_at(idx_r));

  // multiplier operand select
  always_comb begin
    ma = r_r;
    mb = b_r;
    unique case (cmd.sel)
      SEL_RB: begin
        ma = r_r; mb = b_r;
      end
      SEL_BB: begin
        ma = b_r; mb = b_r;
      end
      SEL_XX: begin
        ma = r_r; mb = r_r;
      end
      default: ma = r_r;
    endcase
  end

  mr_mulmod #(.W(W)) u_mul (
    .clk(clk), .rst_n(rst_n), .start(cmd.mul_start),
    .a(ma), .b(mb), .m(n_r), .busy(mbusy), .result(mres)
  );

  // register updates by command
  always_comb begin
    n_nxt = n_r; d_nxt = d_r; e_nxt = e_r; r_nxt = r_r; b_nxt = b_r;
    s_nxt = s_r; cnt_nxt = cnt_r; idx_nxt = idx_r;
    unique case (cmd.op)
      OP_LOAD: begin
        n_nxt = cand; d_nxt = cand - W'(1); s_nxt = '0; idx_nxt = '0;
      end
      OP_SHIFT_D: begin
        d_nxt = d_r >> 1; s_nxt = s_r + SW'(1);
      end
      OP_LOAD_BASE: begin
        r_nxt = W'(1); b_nxt = base_v; e_nxt = d_r; cnt_nxt = SW'(1);
      end
      OP_MUL_RB: r_nxt = mres;
      // squared base taken, move to the next exponent bit
      OP_MUL_BB: begin
        b_nxt = mres; e_nxt = e_r >> 1;
      end
      OP_MUL_XX: begin
        r_nxt = mres; cnt_nxt = cnt_r + SW'(1);
      end
      OP_NEXT_BASE: idx_nxt = idx_r + BaseIdxW'(1);
      default: n_nxt = n_r;
    endcase
  end

  always_ff @(posedge clk) begin
    n_r <= n_nxt; d_r <= d_nxt; e_r <= e_nxt; r_r <= r_nxt; b_r <= b_nxt;
    s_r <= s_nxt; cnt_r <= cnt_nxt; idx_r <= idx_nxt;
  end

  // status toward the controller
  always_comb begin
    status.trivial = (n_r < W'(4)) || !n_r[0];
    status.trivial_prime = (n_r == W'(2)) || (n_r == W'(3));
    status.d_even = !d_r[0];
    status.base_ok = (idx_r < BaseIdxW'(BaseCount)) && (base_v < n_r);
    status.e_zero = (e_r == '0);
    status.e_bit = e_r[0];
    status.mul_busy = mbusy;
    status.x_one = (r_r == W'(1));
    status.x_nm1 = (r_r == nm1);
    status.r_done = (cnt_r >= s_r);
  end
endmodule

@@ rtl/mr_ctrl.sv @@
// controller state machine for the miller-rabin sequence
module mr_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_fire,
  input  logic               out_free,
  input  mr_pkg::mr_status_t status,
  output mr_pkg::mr_cmd_t    cmd,
  output logic               busy,
  output logic               done,
  output logic               verdict
);
  import mr_pkg::*;

  mr_state_t state_r, state_nxt;
  logic verdict_r, verdict_nxt, wait_r, wait_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      wait_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      wait_r <= wait_nxt;
    end
    verdict_r <= verdict_nxt;
  end

  // next state and commands; wait_r marks a multiply just started
  always_comb begin
    state_nxt = state_r;
    verdict_nxt = verdict_r;
    wait_nxt = wait_r;
    cmd.op = OP_NONE;
    cmd.sel = SEL_RB;
    cmd.mul_start = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          cmd.op = OP_LOAD;
          state_nxt = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        if (status.trivial) begin
          verdict_nxt = status.trivial_prime;
          state_nxt = ST_DONE;
        end else if (status.d_even) begin
          cmd.op = OP_SHIFT_D;
        end else begin
          state_nxt = ST_BASE;
        end
      end
      ST_BASE: begin
        if (!status.base_ok) begin
          verdict_nxt = 1'b1;
          state_nxt = ST_DONE;
        end else begin
          cmd.op = OP_LOAD_BASE;
          state_nxt = ST_POW_STEP;
        end
      end
      ST_POW_STEP: begin
        if (status.e_zero) begin
          state_nxt = ST_CHECK;
        end else if (status.e_bit) begin
          cmd.sel = SEL_RB;
          cmd.mul_start = 1'b1;
          wait_nxt = 1'b1;
          state_nxt = ST_POW_MUL;
        end else begin
          cmd.sel = SEL_BB;
          cmd.mul_start = 1'b1;
          wait_nxt = 1'b1;
          state_nxt = ST_POW_SQR;
        end
      end
      ST_POW_MUL: begin
        // take r*b and start squaring the base in the same cycle
        if (wait_r) begin
          wait_nxt = 1'b0;
        end else if (!status.mul_busy) begin
          cmd.op = OP_MUL_RB;
          cmd.sel = SEL_BB;
          cmd.mul_start = 1'b1;
          wait_nxt = 1'b1;
          state_nxt = ST_POW_SQR;
        end
      end
      ST_POW_SQR: begin
        if (wait_r) begin
          wait_nxt = 1'b0;
        end else if (!status.mul_busy) begin
          cmd.op = OP_MUL_BB;
          state_nxt = ST_POW_STEP;
        end
      end
      ST_CHECK: begin
        if (status.x_one || status.x_nm1) begin
          cmd.op = OP_NEXT_BASE;
          state_nxt = ST_BASE;
        end else if (status.r_done) begin
          verdict_nxt = 1'b0;
          state_nxt = ST_DONE;
        end else begin
          cmd.sel = SEL_XX;
          cmd.mul_start = 1'b1;
          wait_nxt = 1'b1;
          state_nxt = ST_SQR;
        end
      end
      ST_SQR: begin
        if (wait_r) begin
          wait_nxt = 1'b0;
        end else if (!status.mul_busy) begin
          cmd.op = OP_MUL_XX;
          state_nxt = ST_SQR_CHK;
        end
      end
      ST_SQR_CHK: begin
        if (status.x_nm1) begin
          cmd.op = OP_NEXT_BASE;
          state_nxt = ST_BASE;
        end else if (status.r_done) begin
          verdict_nxt = 1'b0;
          state_nxt = ST_DONE;
        end else begin
          cmd.sel = SEL_XX;
          cmd.mul_start = 1'b1;
          wait_nxt = 1'b1;
          state_nxt = ST_SQR;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign busy = (state_r != ST_IDLE);
  assign done = (state_r == ST_DONE);
  assign verdict = verdict_r;
endmodule

@@ rtl/miller_rabin_prime_test.sv @@
// top level of the deterministic miller-rabin prime tester
// trivial values are settled without any multiply; otherwise, for each of up to
// 15 bases, one squaring of the base per exponent bit, one more multiply per set
// bit and the squarings of x, all on the one shared shift-and-add multiplier
// throughput: one candidate at a time; next transfer taken after the result
// moves into the output register; rst_n (synchronous, active low) clears control
module miller_rabin_prime_test #(
  parameter int WORD_WIDTH = mr_pkg::WordWidth
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [63:0] in_tdata,  // [63:0] candidate
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata   // [0] is_prime, [7:1] zero
);
  import mr_pkg::*;

  mr_cmd_t cmd;
  mr_status_t status;
  logic busy, done, verdict, in_fire, out_free;
  logic ov_r, ov_nxt, op_r, op_nxt;

  assign in_tready = !busy;
  assign in_fire = in_tvalid && in_tready;
  assign out_free = !ov_r || out_tready;

  mr_datapath #(.W(WORD_WIDTH)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd),
    .cand(in_tdata[WORD_WIDTH-1:0]), .status(status)
  );

  mr_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .out_free(out_free),
    .status(status), .cmd(cmd), .busy(busy), .done(done), .verdict(verdict)
  );

  // output register
  always_comb begin
    ov_nxt = ov_r;
    op_nxt = op_r;
    if (ov_r && out_tready) ov_nxt = 1'b0;
    if (done && out_free) begin
      ov_nxt = 1'b1;
      op_nxt = verdict;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else begin
      ov_r <= ov_nxt;
    end
    op_r <= op_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_tdata = {7'd0, op_r};

`ifndef SYNTHESIS
  a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !in_tready) else $error("input taken while busy");
  a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (done && out_free) |=> out_tvalid) else $error("result not registered");
  a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("output dropped");
`endif
endmodule
